>>> sv/dbsg_pkg.sv
package dbsg_pkg;

  // Fixed field widths
  localparam int DIGIT_W = 3;
  localparam int SYM_W   = 8;
  localparam int PDATA_W = 64;
  localparam int PADDR_W = 5;

  // Register reset values
  localparam logic [3:0]  ALPHABET_RST = 4'd2;
  localparam logic [4:0]  ORDER_RST    = 5'd3;
  localparam logic        CYCLIC_RST   = 1'b1;
  localparam logic [63:0] SYMMAP_RST   = 64'h0706050403020100;

  // Register index, taken from paddr[4:3]
  typedef enum logic [1:0] {
    REG_ALPHABET = 2'd0,
    REG_ORDER    = 2'd1,
    REG_CYCLIC   = 2'd2,
    REG_SYMMAP   = 2'd3
  } reg_idx_t;

  // Sequence phase
  typedef enum logic [1:0] {
    PH_GEN  = 2'd0,
    PH_TAIL = 2'd1,
    PH_DONE = 2'd2
  } phase_t;

  // Walker sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_FIND,
    ST_EXT_WR,
    ST_BACK_RD,
    ST_BACK_CHK,
    ST_EMIT_RD,
    ST_EMIT,
    ST_OUT
  } walk_state_t;

  // Register file contents plus write strobe
  typedef struct packed {
    logic [3:0]  alphabet_size;
    logic [4:0]  word_order;
    logic        cyclic_mode;
    logic [63:0] symbol_map;
    logic        wr;
  } cfg_t;

  // Result handed from walker to output stage
  typedef struct packed {
    logic [DIGIT_W-1:0] digit;
    logic               last;
    logic               done_res;
  } res_t;

endpackage

>>> sv/dbsg_if.sv
// Request channel: one request asks for one symbol
interface dbsg_req_if;
  logic valid;
  logic ready;
  logic restart;
  modport source (output valid, output restart, input ready);
  modport sink (input valid, input restart, output ready);
endinterface

// Result channel
interface dbsg_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] symbol;
  logic [2:0] digit;
  logic       last;
  logic       done_res;
  modport source (output valid, output symbol, output digit, output last, output done_res,
                  input ready);
  modport sink (input valid, input symbol, input digit, input last, input done_res,
                output ready);
endinterface

>>> sv/dbsg_cfg_regs.sv
module dbsg_cfg_regs
  import dbsg_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output cfg_t               cfg
);

  logic [3:0]  alphabet_size;
  logic [4:0]  word_order;
  logic        cyclic_mode;
  logic [63:0] symbol_map;
  logic        wr_en;
  reg_idx_t    idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = reg_idx_t'(paddr[4:3]);

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      alphabet_size <= ALPHABET_RST;
      word_order    <= ORDER_RST;
      cyclic_mode   <= CYCLIC_RST;
      symbol_map    <= SYMMAP_RST;
    end else if (wr_en) begin
      case (idx)
        REG_ALPHABET: alphabet_size <= pwdata[3:0];
        REG_ORDER:    word_order    <= pwdata[4:0];
        REG_CYCLIC:   cyclic_mode   <= pwdata[0];
        REG_SYMMAP:   symbol_map    <= pwdata;
        default: ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    case (idx)
      REG_ALPHABET: prdata = {60'd0, alphabet_size};
      REG_ORDER:    prdata = {59'd0, word_order};
      REG_CYCLIC:   prdata = {63'd0, cyclic_mode};
      REG_SYMMAP:   prdata = symbol_map;
      default:      prdata = '0;
    endcase
  end

  // Any write restarts the sequence
  assign cfg = '{alphabet_size: alphabet_size, word_order: word_order,
                 cyclic_mode: cyclic_mode, symbol_map: symbol_map, wr: wr_en};

endmodule

>>> sv/dbsg_digit_ram.sv
module dbsg_digit_ram
  import dbsg_pkg::*;
#(
  parameter int MAX_ORDER = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 clr,
  input  logic                                 we,
  input  logic [$clog2(MAX_ORDER+1)-1:0]       waddr,
  input  logic [DIGIT_W-1:0]                   wdata,
  input  logic [$clog2(MAX_ORDER+1)-1:0]       raddr,
  output logic [DIGIT_W-1:0]                   rdata
);

  localparam int DEPTH = MAX_ORDER + 1;

  logic [DIGIT_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]   vld;

  // Valid bits: an entry not written since restart reads as zero
  always_ff @(posedge clk) begin
    if (rst || clr) begin
      vld <= '0;
    end else if (we) begin
      vld[waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read
  always_ff @(posedge clk) begin
    rdata <= vld[raddr] ? mem[raddr] : '0;
  end

endmodule

>>> sv/dbsg_walker.sv
module dbsg_walker
  import dbsg_pkg::*;
#(
  parameter int MAX_ORDER    = 16,
  parameter int MAX_ALPHABET = 8
) (
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       cfg,
  dbsg_req_if.sink   req,
  output logic       rslt_valid,
  input  logic       rslt_ready,
  output res_t       rslt
);

  localparam int POS_W  = $clog2(MAX_ORDER + 2);
  localparam int ADDR_W = $clog2(MAX_ORDER + 1);

  walk_state_t state, state_next;
  phase_t      phase, phase_next, end_phase;
  logic [POS_W-1:0] ext, ext_next;
  logic [POS_W-1:0] per, per_next;
  logic [POS_W-1:0] emit, emit_next;
  logic [POS_W-1:0] tail, tail_next;
  logic [POS_W-1:0] tpos, tpos_next;
  logic [POS_W-1:0] modc, modc_next;
  logic             emitted, emitted_next;
  res_t             res_q, res_next;

  logic [POS_W-1:0]   n_eff, emit_inc, tail_inc, modc_inc;
  logic [DIGIT_W-1:0] lim;
  logic               restart_now;

  logic               ram_clr, ram_we;
  logic [ADDR_W-1:0]  ram_waddr, ram_raddr;
  logic [DIGIT_W-1:0] ram_wdata, ram_rdata;

  dbsg_digit_ram #(.MAX_ORDER(MAX_ORDER)) u_ram (
    .clk   (clk),
    .rst   (rst),
    .clr   (ram_clr),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Clamped k-1 and n
  always_comb begin
    if (cfg.alphabet_size == '0) begin
      lim = '0;
    end else if (int'(cfg.alphabet_size) > MAX_ALPHABET) begin
      lim = DIGIT_W'(MAX_ALPHABET - 1);
    end else begin
      lim = DIGIT_W'(cfg.alphabet_size - 4'd1);
    end
    if (cfg.word_order == '0) begin
      n_eff = POS_W'(1);
    end else if (int'(cfg.word_order) > MAX_ORDER) begin
      n_eff = POS_W'(MAX_ORDER);
    end else begin
      n_eff = POS_W'(cfg.word_order);
    end
  end

  assign end_phase = (!cfg.cyclic_mode && n_eff > POS_W'(1)) ? PH_TAIL : PH_DONE;
  assign emit_inc  = emit + POS_W'(1);
  assign tail_inc  = tail + POS_W'(1);
  assign modc_inc  = modc + POS_W'(1);
  assign rslt      = res_q;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      phase   <= PH_GEN;
      ext     <= POS_W'(1);
      per     <= POS_W'(1);
      emit    <= '0;
      tail    <= '0;
      tpos    <= '0;
      modc    <= '0;
      emitted <= 1'b0;
    end else begin
      state   <= state_next;
      phase   <= phase_next;
      ext     <= ext_next;
      per     <= per_next;
      emit    <= emit_next;
      tail    <= tail_next;
      tpos    <= tpos_next;
      modc    <= modc_next;
      emitted <= emitted_next;
    end
  end

  always_ff @(posedge clk) begin
    res_q <= res_next;
  end

  // Sequencer: extend, backtrack and emit, at most one RAM access per step
  always_comb begin
    state_next   = state;
    phase_next   = phase;
    ext_next     = ext;
    per_next     = per;
    emit_next    = emit;
    tail_next    = tail;
    tpos_next    = tpos;
    modc_next    = modc;
    emitted_next = emitted;
    res_next     = res_q;
    ram_clr      = 1'b0;
    ram_we       = 1'b0;
    ram_waddr    = '0;
    ram_wdata    = '0;
    ram_raddr    = '0;
    rslt_valid   = 1'b0;
    req.ready    = (state == ST_IDLE);
    restart_now  = cfg.wr || (req.valid && req.ready && req.restart);

    case (state)
      ST_IDLE: begin
        if (req.valid) state_next = ST_DISPATCH;
      end

      ST_DISPATCH: begin
        emitted_next = 1'b0;
        res_next     = '0;
        case (phase)
          PH_GEN: begin
            state_next = (emit == '0) ? ST_FIND : ST_EMIT_RD;
          end
          PH_TAIL: begin
            tail_next  = tail_inc;
            if (tail_inc >= n_eff - POS_W'(1)) begin
              phase_next    = PH_DONE;
              res_next.last = 1'b1;
            end
            state_next = ST_OUT;
          end
          default: begin
            res_next.done_res = 1'b1;
            state_next        = ST_OUT;
          end
        endcase
      end

      // Extend the prefix, select the word when n mod p is zero, else backtrack
      ST_FIND: begin
        if (ext <= n_eff) begin
          ram_raddr  = ADDR_W'(ext - per);
          state_next = ST_EXT_WR;
        end else if (modc == '0) begin
          emit_next  = POS_W'(1);
          state_next = emitted ? ST_OUT : ST_EMIT_RD;
        end else begin
          tpos_next  = n_eff;
          state_next = ST_BACK_RD;
        end
      end

      ST_EXT_WR: begin
        ram_we     = 1'b1;
        ram_waddr  = ADDR_W'(ext);
        ram_wdata  = ram_rdata;
        ext_next   = ext + POS_W'(1);
        modc_next  = (modc_inc == per) ? '0 : modc_inc;
        state_next = ST_FIND;
      end

      // Scan down for the last digit below k-1
      ST_BACK_RD: begin
        if (tpos == '0) begin
          emit_next  = '0;
          tail_next  = '0;
          phase_next = end_phase;
          if (emitted) begin
            res_next.last = (end_phase == PH_DONE);
            state_next    = ST_OUT;
          end else begin
            state_next = ST_DISPATCH;
          end
        end else begin
          ram_raddr  = ADDR_W'(tpos);
          state_next = ST_BACK_CHK;
        end
      end

      ST_BACK_CHK: begin
        if (ram_rdata == lim) begin
          tpos_next  = tpos - POS_W'(1);
          state_next = ST_BACK_RD;
        end else begin
          ram_we     = 1'b1;
          ram_waddr  = ADDR_W'(tpos);
          ram_wdata  = ram_rdata + DIGIT_W'(1);
          per_next   = tpos;
          ext_next   = tpos + POS_W'(1);
          modc_next  = '0;
          state_next = ST_FIND;
        end
      end

      ST_EMIT_RD: begin
        ram_raddr  = (int'(emit) <= MAX_ORDER) ? ADDR_W'(emit) : '0;
        state_next = ST_EMIT;
      end

      ST_EMIT: begin
        res_next.digit = ram_rdata;
        emitted_next   = 1'b1;
        emit_next      = emit_inc;
        if (emit_inc > per) begin
          tpos_next  = n_eff;
          state_next = ST_BACK_RD;
        end else begin
          state_next = ST_OUT;
        end
      end

      ST_OUT: begin
        rslt_valid = 1'b1;
        if (rslt_ready) state_next = ST_IDLE;
      end

      default: state_next = ST_IDLE;
    endcase

    // Fresh sequence on restart request or register write
    if (restart_now) begin
      ram_clr    = 1'b1;
      ext_next   = POS_W'(1);
      per_next   = POS_W'(1);
      emit_next  = '0;
      tail_next  = '0;
      modc_next  = '0;
      phase_next = PH_GEN;
    end
  end

  // Checks that digit RAM clear and write never coincide
  a_clr_we: assert property (@(posedge clk) disable iff (rst) !(ram_clr && ram_we))
    else $error("digit RAM clear and write in one cycle");

  // Restart leaves the walk at its start
  a_restart: assert property (@(posedge clk) disable iff (rst)
    restart_now |=> (ext == POS_W'(1) && per == POS_W'(1) && emit == '0 && phase == PH_GEN))
    else $error("restart did not reinitialize walk");

  // Between requests the emit position stays within the word
  a_emit_rng: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE && phase == PH_GEN) |-> (emit <= per && per <= n_eff))
    else $error("emit position beyond current word");

  // Tail count stays below n-1 while in the tail
  a_tail_rng: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE && phase == PH_TAIL) |-> (tail < n_eff - POS_W'(1)))
    else $error("tail count overran");

endmodule

>>> sv/de_bruijn_sequence_generator_core.sv
// Channel   Dir   Payload                              Handshake
// req       in    restart                              valid/ready
// res       out   symbol, digit, last, done_res        valid/ready
// cfg       in    alphabet_size, word_order,           APB write, pready tied high
//                 cyclic_mode, symbol_map
//
// One request at a time. A tail or done request passes DISPATCH and OUT; a symbol
// inside the current word passes DISPATCH, EMIT_RD, EMIT and OUT. Ending a word adds
// a digit RAM read and a step using it per digit scanned or extended, and a step
// per prefix checked. Synchronous reset loads register defaults and clears the walk
// at once. A register write or a restart request clears the digit RAM valid bits.
// The result register holds one result, letting the sequencer finish one more while res stalls.
module de_bruijn_sequence_generator_core
  import dbsg_pkg::*;
#(
  parameter int MAX_ORDER    = 16,
  parameter int MAX_ALPHABET = 8
) (
  input  logic               clk,
  input  logic               rst,
  dbsg_req_if.sink           req,
  dbsg_res_if.source         res,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  cfg_t cfg;
  res_t rslt;
  logic rslt_valid, rslt_ready, out_valid;

  dbsg_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  dbsg_walker #(
    .MAX_ORDER    (MAX_ORDER),
    .MAX_ALPHABET (MAX_ALPHABET)
  ) u_walker (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .req        (req),
    .rslt_valid (rslt_valid),
    .rslt_ready (rslt_ready),
    .rslt       (rslt)
  );

  assign rslt_ready = !out_valid || res.ready;

  // Output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (rslt_valid && rslt_ready) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  // Output payload with symbol lookup
  always_ff @(posedge clk) begin
    if (rslt_valid && rslt_ready) begin
      res.symbol   <= rslt.done_res ? '0 : cfg.symbol_map[{rslt.digit, 3'b000} +: SYM_W];
      res.digit    <= rslt.digit;
      res.last     <= rslt.last;
      res.done_res <= rslt.done_res;
    end
  end

  assign res.valid = out_valid;

endmodule

>>> bench/tb.sv
module tb;
  import dbsg_pkg::*;

  localparam int ORDER_MAX     = 16;
  localparam int ALPHA_MAX     = 8;
  localparam int SETTLE_CYCLES = 100;
  localparam int ITEM_TARGET   = 1150;

  // One predicted result
  typedef struct {
    logic [7:0] symbol;
    logic [2:0] digit;
    logic       last;
    logic       done_res;
  } sym_res_t;

  logic               clk;
  logic               rst;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  dbsg_req_if req_ch();
  dbsg_res_if res_ch();

  de_bruijn_sequence_generator_core u_top (
    .clk     (clk),
    .rst     (rst),
    .req     (req_ch),
    .res     (res_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Predictor copy of the registers
  logic [3:0]  cfg_k;
  logic [4:0]  cfg_n;
  logic        cfg_cyc;
  logic [63:0] cfg_map;

  // Predictor copy of the Lyndon-word walk
  logic [2:0]  dig [0:ORDER_MAX];
  int unsigned ext_pos;
  int unsigned per_len;
  int unsigned emit_idx;
  int unsigned tail_cnt;
  phase_t      ph;

  sym_res_t pending_syms[$];

  int  errors;
  int  sent_count;
  int  checked_count;
  int  setting_count;
  bit  steady;
  int  hold_cycles_req;

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run limit
  initial begin
    #15_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  function automatic int unsigned alpha_count();
    if (cfg_k == 0) return 1;
    if (cfg_k > ALPHA_MAX) return ALPHA_MAX;
    return cfg_k;
  endfunction

  function automatic int unsigned order_len();
    if (cfg_n == 0) return 1;
    if (cfg_n > ORDER_MAX) return ORDER_MAX;
    return cfg_n;
  endfunction

  function automatic void walk_clear();
    for (int i = 0; i <= ORDER_MAX; i++) dig[i] = '0;
    ext_pos  = 1;
    per_len  = 1;
    emit_idx = 0;
    tail_cnt = 0;
    ph       = PH_GEN;
  endfunction

  // Next prefix in lexicographic order; 0 when the walk is over
  function automatic bit walk_backtrack();
    int unsigned lim;
    int unsigned t;
    lim = alpha_count() - 1;
    t   = order_len();
    while (t > 0 && dig[t] == lim) t--;
    if (t == 0) return 1'b0;
    dig[t]  = dig[t] + 3'd1;
    per_len = t;
    ext_pos = t + 1;
    return 1'b1;
  endfunction

  // Extend/backtrack until a word whose length divides n is selected
  function automatic bit walk_seek();
    int unsigned n;
    n = order_len();
    while (1) begin
      if (ext_pos <= n) begin
        dig[ext_pos] = dig[ext_pos - per_len];
        ext_pos++;
      end else if (n % per_len == 0) begin
        emit_idx = 1;
        return 1'b1;
      end else if (!walk_backtrack()) begin
        return 1'b0;
      end
    end
  endfunction

  function automatic void walk_finish();
    emit_idx = 0;
    tail_cnt = 0;
    if (!cfg_cyc && order_len() > 1) ph = PH_TAIL;
    else ph = PH_DONE;
  endfunction

  // Result of one request
  function automatic sym_res_t next_symbol(input bit rs);
    sym_res_t    r;
    int unsigned d;
    bit          lst;
    bit          dn;
    d   = 0;
    lst = 1'b0;
    dn  = 1'b0;
    if (rs) walk_clear();
    if (ph == PH_GEN && emit_idx == 0) begin
      if (!walk_seek()) walk_finish();
    end
    if (ph == PH_GEN) begin
      d = dig[(emit_idx <= ORDER_MAX) ? emit_idx : 0];
      emit_idx++;
      if (emit_idx > per_len) begin
        if (!walk_backtrack() || !walk_seek()) walk_finish();
      end
      if (ph == PH_DONE) lst = 1'b1;
    end else if (ph == PH_TAIL) begin
      tail_cnt++;
      if (tail_cnt >= order_len() - 1) begin
        ph  = PH_DONE;
        lst = 1'b1;
      end
    end else begin
      dn = 1'b1;
    end
    if (dn) begin
      r.symbol = '0;
      r.digit  = '0;
    end else begin
      r.symbol = cfg_map[8*d +: 8];
      r.digit  = d[2:0];
    end
    r.last     = lst;
    r.done_res = dn;
    return r;
  endfunction

  function automatic void load_register(input reg_idx_t idx, input logic [63:0] data);
    case (idx)
      REG_ALPHABET: cfg_k   = data[3:0];
      REG_ORDER:    cfg_n   = data[4:0];
      REG_CYCLIC:   cfg_cyc = data[0];
      REG_SYMMAP:   cfg_map = data;
      default: ;
    endcase
    walk_clear();
  endfunction

  // Full length of the current sequence, tail included
  function automatic int unsigned seq_span();
    int unsigned p;
    p = 1;
    repeat (order_len()) p = p * alpha_count();
    if (!cfg_cyc && order_len() > 1) p = p + order_len() - 1;
    return p;
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------
  function automatic void compare_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin : check_results
    sym_res_t want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (pending_syms.size() == 0) begin
        $display("%0t: unexpected result: expected none, got symbol %0h digit %0d last %0b done %0b",
                 $time, res_ch.symbol, res_ch.digit, res_ch.last, res_ch.done_res);
        errors++;
      end else begin
        want = pending_syms.pop_front();
        compare_field("symbol", want.symbol, res_ch.symbol);
        compare_field("digit", 8'(want.digit), 8'(res_ch.digit));
        compare_field("last", 8'(want.last), 8'(res_ch.last));
        compare_field("done_res", 8'(want.done_res), 8'(res_ch.done_res));
        checked_count++;
      end
    end
  end

  // Result side ready: random stalls, plus long hold-offs on demand
  initial begin
    int stall_left;
    stall_left   = 0;
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles_req != 0) begin
        stall_left      = hold_cycles_req;
        hold_cycles_req = 0;
      end
      if (stall_left > 0) begin
        res_ch.ready = 1'b0;
        stall_left--;
      end else begin
        res_ch.ready = steady || ($urandom_range(0, 99) >= 17);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------
  // One request; returns right after the accepting edge with valid still high
  task automatic send_request(input bit rs);
    @(negedge clk);
    while (!steady && $urandom_range(0, 99) < 17) begin
      req_ch.valid   = 1'b0;
      req_ch.restart = 1'($urandom_range(0, 1));
      @(negedge clk);
    end
    req_ch.valid   = 1'b1;
    req_ch.restart = rs;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    pending_syms = {pending_syms, next_symbol(rs)};
    sent_count++;
  endtask

  // Stop requesting and wait until every result is back and the block is quiet
  task automatic wait_drain();
    @(negedge clk);
    req_ch.valid = 1'b0;
    while (pending_syms.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apb_write(input reg_idx_t idx, input logic [63:0] data);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 3'b000};
    pwdata  = data;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    load_register(idx, data);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // Write all four registers; unused upper bits carry noise
  task automatic set_config(input logic [3:0] k, input logic [4:0] n, input logic cyc,
                            input logic [63:0] map);
    logic [63:0] fill;
    fill = {$urandom, $urandom};
    wait_drain();
    apb_write(REG_ALPHABET, {fill[63:4], k});
    apb_write(REG_ORDER, {fill[63:5], n});
    apb_write(REG_CYCLIC, {fill[63:1], cyc});
    apb_write(REG_SYMMAP, map);
    setting_count++;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Reset settings: B(2,3) to the end, exhausted requests, then a restart
  task automatic test_default_sequence();
    repeat (8) send_request(1'b0);
    repeat (2) send_request(1'b0);
    send_request(1'b1);
    send_request(1'b0);
  endtask

  // Zero size and order are used as one; cyclic and non-cyclic mode, no wrap tail at order one
  task automatic test_unit_alphabet_and_order();
    set_config(4'd0, 5'd0, 1'b1, 64'h0123_4567_89AB_CDEF);
    repeat (2) send_request(1'b0);
    set_config(4'd1, 5'd1, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF);
    repeat (2) send_request(1'b0);
  endtask

  // Oversized k and n clamp to the maximum
  task automatic test_clamped_extremes();
    set_config(4'd15, 5'd31, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF);
    repeat (3) send_request(1'b0);
    send_request(1'b1);
    send_request(1'b0);
  endtask

  // Non-cyclic mode appends n-1 wrap symbols
  task automatic test_wrap_tail();
    set_config(4'd2, 5'd2, 1'b0, 64'h0000_0000_0000_0000);
    repeat (6) send_request(1'b0);
  endtask

  // Long result stall while requests keep coming, so the input backs up
  task automatic test_backpressure();
    set_config(4'd3, 5'd3, 1'b0, {$urandom, $urandom});
    hold_cycles_req = 200;
    repeat (29) send_request(1'b0);
  endtask

  // Requests stop until all results are back, then resume mid-sequence
  task automatic test_drain_pause();
    set_config(4'd4, 5'd2, 1'b1, {$urandom, $urandom});
    repeat (10) send_request(1'b0);
    wait_drain();
    repeat (8) send_request(1'b0);
  endtask

  // No idling on either side for a whole sequence
  task automatic test_no_idle_stretch();
    set_config(4'd3, 5'd4, 1'b1, {$urandom, $urandom});
    steady = 1'b1;
    repeat (seq_span() + 2) send_request(1'b0);
    wait_drain();
    steady = 1'b0;
  endtask

  // Random settings, mostly whole sequences, with stray restarts
  task automatic test_random_sets();
    logic [3:0]  k_raw;
    logic [4:0]  n_raw;
    int unsigned ke;
    int unsigned nmax;
    int unsigned p;
    int unsigned count;
    bit          big;
    bit          rs;
    while (sent_count < ITEM_TARGET) begin
      big   = ($urandom_range(0, 15) == 0);
      k_raw = big ? 4'($urandom_range(8, 15)) : 4'($urandom_range(0, 15));
      ke    = (k_raw == 0) ? 1 : ((k_raw > ALPHA_MAX) ? ALPHA_MAX : k_raw);
      if (big) begin
        n_raw = 5'($urandom_range(10, 31));
      end else if (ke == 1) begin
        n_raw = 5'($urandom_range(0, 31));
      end else begin
        nmax = 1;
        p    = ke;
        while (p * ke <= 80 && nmax < ORDER_MAX) begin
          p = p * ke;
          nmax++;
        end
        n_raw = 5'($urandom_range(1, nmax));
      end
      set_config(k_raw, n_raw, 1'($urandom_range(0, 1)), {$urandom, $urandom});
      count = big ? $urandom_range(10, 25) : seq_span() + $urandom_range(0, 2);
      for (int i = 0; i < count; i++) begin
        rs = (i == 0) ? ($urandom_range(0, 3) == 0) : ($urandom_range(0, 99) < 3);
        send_request(rs);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    errors          = 0;
    sent_count      = 0;
    checked_count   = 0;
    setting_count   = 0;
    steady          = 1'b0;
    hold_cycles_req = 0;
    rst             = 1'b1;
    req_ch.valid    = 1'b0;
    req_ch.restart  = 1'b0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    cfg_k           = ALPHABET_RST;
    cfg_n           = ORDER_RST;
    cfg_cyc         = CYCLIC_RST;
    cfg_map         = SYMMAP_RST;
    walk_clear();
    repeat (8) @(negedge clk);
    rst = 1'b0;

    test_default_sequence();
    test_unit_alphabet_and_order();
    test_clamped_extremes();
    test_wrap_tail();
    test_backpressure();
    test_drain_pause();
    test_no_idle_stretch();
    test_random_sets();

    wait_drain();
    $display("Checked %0d results from %0d requests over %0d register settings",
             checked_count, sent_count, setting_count);
    $display("Covered restarts, exhausted sequences, wrap tails, clamped sizes, output stalls");
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
